/* sv/dmt_pkg.sv */
`timescale 1ns / 1ps

package dmt_pkg;

  // Fixed field widths of the channels
  localparam int KIND_W   = 2;
  localparam int SAMPLE_W = 24;
  localparam int MS_W     = 32;

  // Defaults for the top-level parameters
  localparam int DMT_COUNTER_BITS = 24;
  localparam int DMT_CYCLE_SHIFT  = 5;
  localparam int DMT_US_PER_MS    = 1000;

  // Request codes; code 3 has no meaning and reports the state like a stopped read
  typedef enum logic [KIND_W-1:0] {
    KIND_START = 2'd0,
    KIND_READ  = 2'd1,
    KIND_STOP  = 2'd2
  } kind_t;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ACC  = 5'b00010,
    ST_ADD  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_RESP = 5'b10000
  } state_t;

  // Divider handshake
  typedef struct packed {
    logic start;
  } dmt_div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dmt_div_sts_t;

endpackage

/* sv/dmt_ifs.sv */
`timescale 1ns / 1ps

// Request channel: kind plus counter sample
interface dmt_in_if import dmt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SAMPLE_W-1:0] counter_sample;

  modport source (output valid, output kind, output counter_sample, input ready);
  modport sink   (input valid, input kind, input counter_sample, output ready);
endinterface

// Result channel: millisecond count plus running flag
interface dmt_out_if import dmt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [MS_W-1:0] milliseconds;
  logic            clock_running;

  modport source (output valid, output milliseconds, output clock_running, input ready);
  modport sink   (input valid, input milliseconds, input clock_running, output ready);
endinterface

/* sv/dmt_div.sv */
`timescale 1ns / 1ps

// Division by a constant through a scaled reciprocal multiply.
// Quotient and remainder are registered and valid with done.
// The reciprocal is rounded up, so the quotient is exact for every dividend below 2^DW.
module dmt_div import dmt_pkg::*; #(
  parameter int DW      = 21,
  parameter int RW      = 10,
  parameter int DIVISOR = DMT_US_PER_MS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  dmt_div_ctl_t  ctl,
  input  logic [DW-1:0] dividend,
  output dmt_div_sts_t  sts,
  output logic [DW-1:0] quotient,
  output logic [RW-1:0] remainder
);

  localparam int LW = $clog2(DIVISOR);
  localparam int SH = DW + LW;
  localparam int MW = DW + 2;
  localparam int PW = SH + DW;
  localparam logic [63:0] RECIP_L =
    ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MW-1:0] RECIP_C = MW'(RECIP_L);
  localparam logic [DW-1:0] DIV_C   = DW'(DIVISOR);

  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [DW-1:0] quot_r, quot_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic          busy_r, busy_nxt;
  logic          mul_r, mul_nxt;    // product step still to run
  logic          done_r, done_nxt;

  logic [DW-1:0] q_est;
  logic [DW-1:0] q_times_d;
  logic [DW-1:0] r_full;

  // Quotient from the scaled product, remainder by back-multiply
  assign q_est     = prod_r[SH +: DW];
  assign q_times_d = q_est * DIV_C;
  assign r_full    = dvd_r - q_times_d;

  always_comb begin
    dvd_nxt  = dvd_r;
    prod_nxt = prod_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    busy_nxt = busy_r;
    mul_nxt  = mul_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      dvd_nxt  = dividend;
      busy_nxt = 1'b1;
      mul_nxt  = 1'b1;
    end else if (busy_r && mul_r) begin
      prod_nxt = PW'(dvd_r) * PW'(RECIP_C);
      mul_nxt  = 1'b0;
    end else if (busy_r) begin
      quot_nxt = q_est;
      rem_nxt  = r_full[RW-1:0];
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      mul_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      mul_r  <= mul_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    prod_r <= prod_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = quot_r;
  assign remainder = rem_r;

endmodule

/* sv/down_counter_millisecond_timebase.sv */
`timescale 1ns / 1ps

// Channel  | Dir | Handshake    | Payload
// ---------+-----+--------------+------------------------------------
// in_ch    | in  | valid/ready  | kind[1:0], counter_sample[23:0]
// out_ch   | out | valid/ready  | milliseconds[31:0], clock_running
//
// Start, stop, an idle read or unused kind: result valid the cycle after accept.
// Read while running: result valid after these steps in order: cycle sum and shift,
// divider start, reciprocal multiply and back-multiply in the divider, then the count update.
// One request at a time: in_ch.ready is high only when no result is pending.
// A result holds on out_ch until its beat is taken.
// Reset (rst_n low, synchronous) stops the clock and clears all counts.
module down_counter_millisecond_timebase import dmt_pkg::*; #(
  parameter int COUNTER_BITS = DMT_COUNTER_BITS,
  parameter int CYCLE_SHIFT  = DMT_CYCLE_SHIFT,
  parameter int US_PER_MS    = DMT_US_PER_MS
) (
  input  logic      clk,
  input  logic      rst_n,
  dmt_in_if.sink    in_ch,
  dmt_out_if.source out_ch
);

  localparam int CB    = COUNTER_BITS;
  localparam int SUM_W = CB + 1;
  localparam int USP_W = SUM_W - CYCLE_SHIFT;
  localparam int USR_W = $clog2(US_PER_MS);
  localparam int US_W  = ((USP_W > USR_W) ? USP_W : USR_W) + 1;
  localparam int CR_W  = (CYCLE_SHIFT == 0) ? 1 : CYCLE_SHIFT;
  localparam logic [CR_W-1:0] CR_MASK = CR_W'((64'd1 << CYCLE_SHIFT) - 64'd1);

  state_t            state_r, state_nxt;
  logic [MS_W-1:0]   ms_count_r, ms_count_nxt;
  logic [USR_W-1:0]  us_rem_r, us_rem_nxt;
  logic [CR_W-1:0]   cyc_rem_r, cyc_rem_nxt;
  logic [CB-1:0]     last_r, last_nxt;
  logic              running_r, running_nxt;
  logic [CB-1:0]     diff_r, diff_nxt;
  logic [USP_W-1:0]  usp_r, usp_nxt;

  logic [CB-1:0]     sample;
  logic [SUM_W-1:0]  sum;
  logic [US_W-1:0]   dividend;
  logic              in_beat;
  logic              out_beat;

  dmt_div_ctl_t      div_ctl;
  dmt_div_sts_t      div_sts;
  logic [US_W-1:0]   div_quot;
  logic [USR_W-1:0]  div_rem;

  assign in_beat  = in_ch.valid && in_ch.ready;
  assign out_beat = out_ch.valid && out_ch.ready;
  assign sample   = CB'(in_ch.counter_sample);

  // Elapsed cycles plus carried cycles, then whole microseconds plus carried ones
  assign sum      = SUM_W'(diff_r) + SUM_W'(cyc_rem_r);
  assign dividend = US_W'(usp_r) + US_W'(us_rem_r);

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    ms_count_nxt = ms_count_r;
    us_rem_nxt   = us_rem_r;
    cyc_rem_nxt  = cyc_rem_r;
    last_nxt     = last_r;
    running_nxt  = running_r;
    diff_nxt     = diff_r;
    usp_nxt      = usp_r;
    div_ctl      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          state_nxt = ST_RESP;
          unique case (in_ch.kind)
            KIND_START: begin
              if (!running_r) begin
                ms_count_nxt = '0;
                us_rem_nxt   = '0;
                cyc_rem_nxt  = '0;
                last_nxt     = sample;
                running_nxt  = 1'b1;
              end
            end
            KIND_READ: begin
              if (running_r) begin
                diff_nxt  = last_r - sample;
                last_nxt  = sample;
                state_nxt = ST_ACC;
              end
            end
            KIND_STOP: begin
              last_nxt    = '0;
              cyc_rem_nxt = '0;
              us_rem_nxt  = '0;
              running_nxt = 1'b0;
            end
            default: begin
              // unused code: report state only
            end
          endcase
        end
      end
      ST_ACC: begin
        cyc_rem_nxt = sum[CR_W-1:0] & CR_MASK;
        usp_nxt     = USP_W'(sum >> CYCLE_SHIFT);
        state_nxt   = ST_ADD;
      end
      ST_ADD: begin
        div_ctl.start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (div_sts.done) begin
          ms_count_nxt = ms_count_r + MS_W'(div_quot);
          us_rem_nxt   = div_rem;
          state_nxt    = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_beat) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ms_count_r <= '0;
      us_rem_r   <= '0;
      cyc_rem_r  <= '0;
      last_r     <= '0;
      running_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ms_count_r <= ms_count_nxt;
      us_rem_r   <= us_rem_nxt;
      cyc_rem_r  <= cyc_rem_nxt;
      last_r     <= last_nxt;
      running_r  <= running_nxt;
    end
  end

  // Datapath holding registers
  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    usp_r  <= usp_nxt;
  end

  // Microseconds to milliseconds
  dmt_div #(
    .DW      (US_W),
    .RW      (USR_W),
    .DIVISOR (US_PER_MS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (dividend),
    .sts       (div_sts),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Handshake and result
  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = (state_r == ST_RESP);
  assign out_ch.milliseconds  = ms_count_r;
  assign out_ch.clock_running = running_r;

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("request taken while a result is pending");

  a_us_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(us_rem_r) < 32'(US_PER_MS)))
    else $error("microsecond remainder out of range");

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && (in_ch.kind == KIND_STOP)) |=> (!running_r && (cyc_rem_r == '0)))
    else $error("stop did not halt the clock");

  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    (div_sts.busy || div_sts.done) |-> (state_r == ST_DIV))
    else $error("divider active outside divide step");

endmodule
